// ----- hw/rtl/a51_pkg.sv -----
// shared types and constants for the a5/1 keystream cipher
package a51_pkg;

    localparam int LFSR_ONE_W   = 19;
    localparam int LFSR_TWO_W   = 22;
    localparam int LFSR_THREE_W = 23;

    localparam int KEY_BITS     = 64;
    localparam int FRAME_BITS   = 22;
    localparam int WARMUP_STEPS = 100;
    localparam int BYTE_STEPS   = 8;
    localparam int LOAD_BITS    = KEY_BITS + FRAME_BITS;

    localparam int CNT_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = KEY_BITS;
    localparam int DATA_W       = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIPHER_KEY   = 2'd0,
        CFG_FRAME_NUMBER = 2'd1
    } cfg_index_t;

    // datapath commands from the controller
    typedef struct packed {
        logic capture;   // latch data byte
        logic clear;     // clear lfsrs, load key and frame into load shifter
        logic forced;    // forced clocking with one load bit
        logic majority;  // majority clocked step, output discarded
        logic collect;   // majority clocked step, keystream bit kept
        logic emit;      // load output register
    } dp_cmd_t;

endpackage

// ----- hw/rtl/a51_stream_if.sv -----
// valid/ready channels for input and result words
interface a51_in_if;
    logic                          valid;
    logic                          ready;
    logic                          start_message;
    logic [a51_pkg::DATA_W-1:0]    data_byte;

    modport source (output valid, output start_message, output data_byte, input ready);
    modport sink   (input valid, input start_message, input data_byte, output ready);
endinterface

interface a51_out_if;
    logic                          valid;
    logic                          ready;
    logic [a51_pkg::DATA_W-1:0]    out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ----- hw/rtl/a51_datapath.sv -----
// lfsr datapath: three registers, key/frame load shifter, keystream byte and output register
module a51_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  a51_pkg::dp_cmd_t                cmd,
    input  logic [a51_pkg::DATA_W-1:0]      data_byte,
    input  logic                            cfg_we,
    input  logic [a51_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [a51_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [a51_pkg::DATA_W-1:0]      out_byte
);

    logic [a51_pkg::KEY_BITS-1:0]     key_reg;
    logic [a51_pkg::FRAME_BITS-1:0]   frame_reg;
    logic [a51_pkg::LOAD_BITS-1:0]    load_sr_reg;
    logic [a51_pkg::LFSR_ONE_W-1:0]   r1_reg, r1_next, r1_shift;
    logic [a51_pkg::LFSR_TWO_W-1:0]   r2_reg, r2_next, r2_shift;
    logic [a51_pkg::LFSR_THREE_W-1:0] r3_reg, r3_next, r3_shift;
    logic [a51_pkg::DATA_W-1:0]       data_reg;
    logic [a51_pkg::DATA_W-1:0]       ks_reg;
    logic [a51_pkg::DATA_W-1:0]       out_reg;
    logic                             c1, c2, c3, maj, ks_bit, load_bit;

    assign r1_shift = {r1_reg[17:0], r1_reg[18] ^ r1_reg[17] ^ r1_reg[16] ^ r1_reg[13]};
    assign r2_shift = {r2_reg[20:0], r2_reg[21] ^ r2_reg[20]};
    assign r3_shift = {r3_reg[21:0], r3_reg[22] ^ r3_reg[21] ^ r3_reg[20] ^ r3_reg[7]};

    assign c1       = r1_reg[8];
    assign c2       = r2_reg[10];
    assign c3       = r3_reg[10];
    assign maj      = (c1 & c2) | (c2 & c3) | (c1 & c3);
    assign load_bit = load_sr_reg[0];

    always_comb
    begin
        r1_next = r1_reg;
        r2_next = r2_reg;
        r3_next = r3_reg;
        if (cmd.clear)
        begin
            r1_next = '0;
            r2_next = '0;
            r3_next = '0;
        end
        else if (cmd.forced)
        begin
            r1_next = {r1_shift[a51_pkg::LFSR_ONE_W-1:1], r1_shift[0] ^ load_bit};
            r2_next = {r2_shift[a51_pkg::LFSR_TWO_W-1:1], r2_shift[0] ^ load_bit};
            r3_next = {r3_shift[a51_pkg::LFSR_THREE_W-1:1], r3_shift[0] ^ load_bit};
        end
        else if (cmd.majority || cmd.collect)
        begin
            if (c1 == maj)
            begin
                r1_next = r1_shift;
            end
            if (c2 == maj)
            begin
                r2_next = r2_shift;
            end
            if (c3 == maj)
            begin
                r3_next = r3_shift;
            end
        end
    end

    // keystream bit is taken after the step
    assign ks_bit = r1_next[a51_pkg::LFSR_ONE_W-1] ^ r2_next[a51_pkg::LFSR_TWO_W-1]
                  ^ r3_next[a51_pkg::LFSR_THREE_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            frame_reg <= '0;
            r1_reg    <= '0;
            r2_reg    <= '0;
            r3_reg    <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == a51_pkg::CFG_CIPHER_KEY))
            begin
                key_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == a51_pkg::CFG_FRAME_NUMBER))
            begin
                frame_reg <= cfg_data[a51_pkg::FRAME_BITS-1:0];
            end
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            load_sr_reg <= {frame_reg, key_reg};
        end
        else if (cmd.forced)
        begin
            load_sr_reg <= {1'b0, load_sr_reg[a51_pkg::LOAD_BITS-1:1]};
        end
        if (cmd.capture)
        begin
            data_reg <= data_byte;
        end
        // first keystream bit ends up in the lsb
        if (cmd.collect)
        begin
            ks_reg <= {ks_bit, ks_reg[a51_pkg::DATA_W-1:1]};
        end
        if (cmd.emit)
        begin
            out_reg <= data_reg ^ ks_reg;
        end
    end

    assign out_byte = out_reg;

endmodule

// ----- hw/rtl/a51_controller.sv -----
// sequencer for key/frame load, warm-up and per-byte keystream steps
module a51_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_start,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output a51_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WARM,
        S_BYTE,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [a51_pkg::CNT_W-1:0]  cnt_reg;
    logic                       out_valid_reg;
    logic                       in_acc, slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = in_acc;
        cmd.clear    = in_acc && in_start;
        cmd.forced   = (state_reg == S_LOAD);
        cmd.majority = (state_reg == S_WARM);
        cmd.collect  = (state_reg == S_BYTE);
        cmd.emit     = (state_reg == S_DONE) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_acc)
                    begin
                        state_reg <= in_start ? S_LOAD : S_BYTE;
                    end
                end
                S_LOAD:
                begin
                    if (cnt_reg == a51_pkg::CNT_W'(a51_pkg::LOAD_BITS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_WARM;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_WARM:
                begin
                    if (cnt_reg == a51_pkg::CNT_W'(a51_pkg::WARMUP_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_BYTE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_BYTE:
                begin
                    if (cnt_reg == a51_pkg::CNT_W'(a51_pkg::BYTE_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_start |=> state_reg == S_LOAD)
        else $error("start word did not enter key load");

    a_plain_skips_init: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !in_start |=> state_reg == S_BYTE && cnt_reg == '0)
        else $error("plain word did not go straight to byte steps");

    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WARM |-> cnt_reg < a51_pkg::CNT_W'(a51_pkg::WARMUP_STEPS))
        else $error("warm-up counter out of range");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside done state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || out_ready)
        else $error("output register overwritten while full");

endmodule

// ----- hw/rtl/a51_keystream_cipher_top.sv -----
// a5/1 keystream cipher top level: one byte in, one byte out
// a plain word runs the byte steps and the done state; a start word first runs
// 86 forced load steps and 100 warm-up steps; words are taken only in idle
// one lfsr step per cycle in the shared registers during load, warm-up and byte steps
// reset: lfsrs, key and frame number clear to zero; no result pending
module a51_keystream_cipher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    a51_in_if.sink                          in_ch,
    a51_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [a51_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [a51_pkg::CFG_DATA_W-1:0]  cfg_data
);

    a51_pkg::dp_cmd_t cmd;

    a51_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_start  (in_ch.start_message),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    a51_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_ch.data_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_byte  (out_ch.out_byte)
    );

endmodule
